[src/pfpe_pkg.sv]
// ----------------------------------------------------------------------------
// pfpe_pkg
// Shared types, codes and constants for the packed framebuffer pixel engine.
// ----------------------------------------------------------------------------
package pfpe_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 128;
  localparam int MAX_HEIGHT_DEFAULT = 64;

  localparam int CMD_W    = 2;
  localparam int COORD_W  = 16;
  localparam int COLOR_W  = 16;
  localparam int SW_W     = 8;
  localparam int SH_W     = 7;
  localparam int DEPTH_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [SW_W-1:0] RST_SCREEN_WIDTH  = 8'd128;
  localparam logic [SH_W-1:0] RST_SCREEN_HEIGHT = 7'd64;

  localparam logic [7:0] LO_NIB_MASK = 8'h0F;
  localparam logic [7:0] HI_NIB_MASK = 8'hF0;
  localparam logic [7:0] BYTE_ONES   = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_FILL = 2'd2
  } cmd_code_t;

  typedef enum logic [DEPTH_W-1:0] {
    DEPTH_1BPP  = 2'd0,
    DEPTH_4BPP  = 2'd1,
    DEPTH_8BPP  = 2'd2,
    DEPTH_16BPP = 2'd3
  } depth_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_DEPTH  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WD_MODIFY   = 2'd0,
    WD_COLOR_LO = 2'd1,
    WD_COLOR_HI = 2'd2,
    WD_FILL     = 2'd3
  } wdata_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_SET_RD,
    ST_SET_MOD,
    ST_SET_LO,
    ST_SET_HI,
    ST_GET_LO,
    ST_GET_HI,
    ST_GET_END,
    ST_FILL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       in_ready;
    logic       load_item;
    logic       calc;
    logic       addr_hi;
    logic       wr;
    wdata_sel_t wsel;
    logic       cap_lo;
    logic       cap_hi;
    logic       fill_step;
    logic       load_result;
  } ctl_t;

  typedef struct packed {
    logic             in_valid;
    logic [CMD_W-1:0] cmd;
    depth_t           depth;
    logic             off;
    logic             fill_empty;
    logic             fill_last;
    logic             out_free;
  } sts_t;

endpackage

[src/pfpe_ifs.sv]
// ----------------------------------------------------------------------------
// pfpe interfaces
// Valid/ready channels: command items, results and register writes.
// ----------------------------------------------------------------------------
interface pfpe_cmd_if;
  import pfpe_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic [COLOR_W-1:0]         pixel_color;
  modport source (output valid, command, pos_x, pos_y, pixel_color, input ready);
  modport sink   (input valid, command, pos_x, pos_y, pixel_color, output ready);
endinterface

interface pfpe_rsp_if;
  import pfpe_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] read_value;
  logic               clipped;
  modport source (output valid, read_value, clipped, input ready);
  modport sink   (input valid, read_value, clipped, output ready);
endinterface

interface pfpe_cfg_if;
  import pfpe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/pfpe_ctrl.sv]
// ----------------------------------------------------------------------------
// pfpe_ctrl
// Command sequencer: steps each item through its frame store accesses.
// ----------------------------------------------------------------------------
module pfpe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  pfpe_pkg::sts_t sts,
  output pfpe_pkg::ctl_t ctl
);
  import pfpe_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.wsel   = WD_MODIFY;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (sts.in_valid) begin
          ctl.load_item = 1'b1;
          state_next    = ST_CALC;
        end
      end
      ST_CALC: begin
        ctl.calc = 1'b1;
        unique case (sts.cmd)
          CMD_SET: begin
            if (sts.off) begin
              state_next = ST_FINISH;
            end else if (sts.depth == DEPTH_1BPP || sts.depth == DEPTH_4BPP) begin
              state_next = ST_SET_RD;
            end else begin
              state_next = ST_SET_LO;
            end
          end
          CMD_GET: begin
            if (sts.off || sts.depth != DEPTH_16BPP) begin
              state_next = ST_FINISH;
            end else begin
              state_next = ST_GET_LO;
            end
          end
          CMD_FILL: begin
            state_next = sts.fill_empty ? ST_FINISH : ST_FILL;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_SET_RD: begin
        state_next = ST_SET_MOD;
      end
      ST_SET_MOD: begin
        ctl.wr     = 1'b1;
        ctl.wsel   = WD_MODIFY;
        state_next = ST_FINISH;
      end
      ST_SET_LO: begin
        ctl.wr     = 1'b1;
        ctl.wsel   = WD_COLOR_LO;
        state_next = (sts.depth == DEPTH_16BPP) ? ST_SET_HI : ST_FINISH;
      end
      ST_SET_HI: begin
        ctl.wr      = 1'b1;
        ctl.wsel    = WD_COLOR_HI;
        ctl.addr_hi = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_GET_LO: begin
        state_next = ST_GET_HI;
      end
      ST_GET_HI: begin
        ctl.addr_hi = 1'b1;
        ctl.cap_lo  = 1'b1;
        state_next  = ST_GET_END;
      end
      ST_GET_END: begin
        ctl.cap_hi = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FILL: begin
        ctl.wr        = 1'b1;
        ctl.wsel      = WD_FILL;
        ctl.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register can take the beat
        if (sts.out_free) begin
          ctl.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/pfpe_datapath.sv]
// ----------------------------------------------------------------------------
// pfpe_datapath
// Registers, address math, byte-wide frame store and result register.
// ----------------------------------------------------------------------------
module pfpe_datapath #(
  parameter int MAX_WIDTH  = pfpe_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = pfpe_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  pfpe_pkg::ctl_t ctl,
  output pfpe_pkg::sts_t sts,
  pfpe_cmd_if.sink       cmd,
  pfpe_rsp_if.source     rsp,
  pfpe_cfg_if.sink       cfg
);
  import pfpe_pkg::*;

  localparam int STORE_BYTES = MAX_WIDTH * MAX_HEIGHT * 2;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;

  // configuration
  logic [SW_W-1:0] screen_width;
  logic [SH_W-1:0] screen_height;
  depth_t          depth_mode;

  // item
  logic [CMD_W-1:0]          item_cmd;
  logic signed [COORD_W-1:0] item_x;
  logic signed [COORD_W-1:0] item_y;
  logic [COLOR_W-1:0]        item_color;

  logic [SW_W-1:0] w_eff;
  logic [SH_W-1:0] h_eff;
  logic            off;

  logic [6:0]      mul_a;
  logic [7:0]      mul_b;
  logic [14:0]     prod;
  logic [7:0]      base_x;
  logic [CW-1:0]   sum;
  logic [CW-1:0]   addr_calc;
  logic [14:0]     pix;
  logic [CW-1:0]   count_calc;

  logic [AW-1:0]   addr;
  logic [AW-1:0]   addr_p1;
  logic [CW-1:0]   fill_count;
  logic [AW-1:0]   fill_cursor;
  logic            fill_last;

  logic [7:0]      frame_store [STORE_BYTES];
  logic [AW-1:0]   mem_ra;
  logic [AW-1:0]   mem_wa;
  logic [7:0]      mem_wd;
  logic [7:0]      rdata;

  logic [7:0]      bit_mask;
  logic [7:0]      fill_lo;
  logic [7:0]      fill_hi;

  logic [COLOR_W-1:0] rv;
  logic               out_valid;
  logic [COLOR_W-1:0] out_value;
  logic               out_clip;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RST_SCREEN_WIDTH;
      screen_height <= RST_SCREEN_HEIGHT;
      depth_mode    <= DEPTH_16BPP;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WIDTH:  screen_width  <= cfg.data[SW_W-1:0];
        REG_HEIGHT: screen_height <= cfg.data[SH_W-1:0];
        REG_DEPTH:  depth_mode    <= depth_t'(cfg.data[DEPTH_W-1:0]);
        default:    ;
      endcase
    end
  end

  assign cmd.ready = ctl.in_ready;

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_cmd   <= cmd.command;
      item_x     <= cmd.pos_x;
      item_y     <= cmd.pos_y;
      item_color <= cmd.pixel_color;
    end
  end

  assign w_eff = (32'(screen_width) > 32'(MAX_WIDTH)) ? SW_W'(MAX_WIDTH) : screen_width;
  assign h_eff = (32'(screen_height) > 32'(MAX_HEIGHT)) ? SH_W'(MAX_HEIGHT) : screen_height;

  assign off = item_x[COORD_W-1] || item_y[COORD_W-1]
            || ({1'b0, item_x[COORD_W-2:0]} >= COORD_W'(w_eff))
            || ({1'b0, item_y[COORD_W-2:0]} >= COORD_W'(h_eff));

  // one row multiply; x and y fit these slices whenever the point is on screen
  always_comb begin
    unique case (depth_mode)
      DEPTH_1BPP: begin
        mul_a  = {3'b000, item_y[6:3]};
        mul_b  = w_eff;
        base_x = item_x[7:0];
      end
      DEPTH_4BPP: begin
        mul_a  = item_y[6:0];
        mul_b  = {1'b0, w_eff[7:1]};
        base_x = {1'b0, item_x[7:1]};
      end
      default: begin
        mul_a  = item_y[6:0];
        mul_b  = w_eff;
        base_x = item_x[7:0];
      end
    endcase
  end

  assign prod      = {8'b0, mul_a} * {7'b0, mul_b};
  assign sum       = CW'(prod) + CW'(base_x);
  assign addr_calc = (depth_mode == DEPTH_16BPP) ? (sum << 1) : sum;

  assign pix = {7'b0, w_eff} * {8'b0, h_eff};

  always_comb begin
    unique case (depth_mode)
      DEPTH_1BPP:  count_calc = CW'(pix >> 3);
      DEPTH_4BPP:  count_calc = CW'(pix >> 1);
      DEPTH_8BPP:  count_calc = CW'(pix);
      DEPTH_16BPP: count_calc = CW'(pix) << 1;
      default:     count_calc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      addr       <= addr_calc[AW-1:0];
      fill_count <= count_calc;
    end
  end

  assign addr_p1   = addr + AW'(1);
  assign fill_last = (CW'(fill_cursor) + CW'(1)) == fill_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cursor <= '0;
    end else if (ctl.fill_step) begin
      fill_cursor <= fill_last ? '0 : fill_cursor + AW'(1);
    end
  end

  // write data
  assign bit_mask = 8'd1 << item_y[2:0];

  always_comb begin
    unique case (depth_mode)
      DEPTH_1BPP: begin
        fill_lo = (item_color != '0) ? BYTE_ONES : 8'h00;
        fill_hi = fill_lo;
      end
      DEPTH_4BPP: begin
        fill_lo = {item_color[3:0], item_color[3:0]};
        fill_hi = fill_lo;
      end
      DEPTH_8BPP: begin
        fill_lo = item_color[7:0];
        fill_hi = fill_lo;
      end
      default: begin
        fill_lo = item_color[7:0];
        fill_hi = item_color[15:8];
      end
    endcase
  end

  always_comb begin
    unique case (ctl.wsel)
      WD_MODIFY: begin
        if (depth_mode == DEPTH_1BPP) begin
          mem_wd = (item_color == COLOR_W'(1)) ? (rdata | bit_mask) : (rdata & ~bit_mask);
        end else if (!item_x[0]) begin
          mem_wd = (rdata & LO_NIB_MASK) | {item_color[3:0], 4'b0000};
        end else begin
          mem_wd = (rdata & HI_NIB_MASK) | {4'b0000, item_color[3:0]};
        end
      end
      WD_COLOR_LO: mem_wd = item_color[7:0];
      WD_COLOR_HI: mem_wd = item_color[15:8];
      WD_FILL:     mem_wd = fill_cursor[0] ? fill_hi : fill_lo;
      default:     mem_wd = rdata;
    endcase
  end

  assign mem_ra = ctl.addr_hi ? addr_p1 : addr;
  assign mem_wa = ctl.fill_step ? fill_cursor : mem_ra;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      frame_store[mem_wa] <= mem_wd;
    end
    rdata <= frame_store[mem_ra];
  end

  // read capture
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      rv <= '0;
    end else begin
      if (ctl.cap_lo) begin
        rv[7:0] <= rdata;
      end
      if (ctl.cap_hi) begin
        rv[15:8] <= rdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_result) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_result) begin
      out_value <= rv;
      out_clip  <= off && (item_cmd == CMD_SET || item_cmd == CMD_GET);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.clipped    = out_clip;

  always_comb begin
    sts.in_valid   = cmd.valid;
    sts.cmd        = item_cmd;
    sts.depth      = depth_mode;
    sts.off        = off;
    sts.fill_empty = (count_calc == '0);
    sts.fill_last  = fill_last;
    sts.out_free   = !out_valid || rsp.ready;
  end

endmodule

[src/packed_framebuffer_pixel_engine_core.sv]
// ----------------------------------------------------------------------------
// packed_framebuffer_pixel_engine_core
// Pixel set/get/fill engine over a packed, depth-configurable frame store.
// ----------------------------------------------------------------------------
// Every command item gives exactly one result beat. The frame store is one
// byte wide, so a pixel access works on it one byte at a time: an on-screen
// set is one byte write at 8 bpp, a read then a modify-write at 1 and 4 bpp,
// and two byte writes at 16 bpp; get at 16 bpp on screen reads the low then
// the high byte; a clipped set, any other get and the unused command code
// touch no byte. Fill writes N bytes, N being the byte count of the active
// screen (W*H/8, W*H/2, W*H or 2*W*H by depth). Items are handled one at a
// time; a finished result sits in an output register so the next item is
// accepted while it waits. The store comes up uninitialized and needs no
// clearing pass; read pixels before writing them are undefined.
module packed_framebuffer_pixel_engine_core #(
  parameter int MAX_WIDTH  = pfpe_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = pfpe_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  pfpe_cmd_if.sink   cmd,
  pfpe_rsp_if.source rsp,
  pfpe_cfg_if.sink   cfg
);
  import pfpe_pkg::*;

  ctl_t ctl;
  sts_t sts;

  pfpe_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  pfpe_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sts (sts),
    .cmd (cmd),
    .rsp (rsp),
    .cfg (cfg)
  );

endmodule

[src/pfpe_checker.sv]
// ----------------------------------------------------------------------------
// pfpe_checker
// Port-level checks on the pixel engine, bound to the top level.
// ----------------------------------------------------------------------------
module pfpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] rsp_read_value,
  input logic        rsp_clipped
);
  import pfpe_pkg::*;

  logic [1:0] outstanding;
  logic       cmd_beat;
  logic       rsp_beat;

  assign cmd_beat = cmd_valid && cmd_ready;
  assign rsp_beat = rsp_valid && rsp_ready;

  // items taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (cmd_beat && !rsp_beat) begin
      outstanding <= outstanding + 2'd1;
    end else if (rsp_beat && !cmd_beat) begin
      outstanding <= outstanding - 2'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped before it was taken");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 2'd2)
    else $error("more than two items in flight");

  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    cmd_beat |-> outstanding <= 2'd1)
    else $error("item accepted while another is still in work");

  a_no_result_unasked: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !$past(rsp_valid) |-> outstanding != 2'd0)
    else $error("result beat without an accepted item");

  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_clipped |-> rsp_read_value == 16'd0)
    else $error("clipped result carries a pixel value");

endmodule

bind packed_framebuffer_pixel_engine_core pfpe_checker u_pfpe_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_value (rsp.read_value),
  .rsp_clipped    (rsp.clipped)
);
